// File: design/radix_ascii_formatter_defines.svh
// ----------------------------------------------------------------------------
// Radix ASCII formatter assertion macros
// Shared property wrappers for the formatter's checks.
// ----------------------------------------------------------------------------
`ifndef RADIX_ASCII_FORMATTER_DEFINES_SVH
`define RADIX_ASCII_FORMATTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RAF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RAF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/raf_pkg.sv
// ----------------------------------------------------------------------------
// Radix ASCII formatter package
// Types, register indexes and fixed constants of the formatter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package raf_pkg;

   localparam int VALUE_W     = 32;
   localparam int CHAR_W      = 8;
   localparam int LEN_W       = 5;
   localparam int ALPHA_CHARS = 16;
   localparam int ALPHA_IDX_W = 4;
   localparam int DIGIT_W     = 4;
   localparam int NIBBLES     = VALUE_W / DIGIT_W;
   localparam int NIB_CNT_W   = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_LOW   = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_HIGH  = 8'd126;
   localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'd0;

   localparam logic [LEN_W-1:0]      BASE_LENGTH_RST = 5'd10;
   localparam logic [CSR_DATA_W-1:0] ALPHA_LOW_RST   = 64'h3736_3534_3332_3130;
   localparam logic [CSR_DATA_W-1:0] ALPHA_HIGH_RST  = 64'h0000_0000_0000_3938;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_LENGTH = 2'd0,
      CSR_ALPHA_LOW   = 2'd1,
      CSR_ALPHA_HIGH  = 2'd2
   } raf_csr_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DIVIDE,
      S_SIGN,
      S_FETCH,
      S_EMIT,
      S_ERROR
   } raf_state_type;

endpackage

`default_nettype wire

// File: design/radix_ascii_formatter.sv
// ----------------------------------------------------------------------------
// Radix ASCII formatter
// Writes a signed 32-bit value as text in a configurable radix and alphabet.
// ----------------------------------------------------------------------------
// Usage: a value is taken when start is high and busy is low. The block then
// checks the alphabet one character per cycle, divides the magnitude by the
// radix one 4-bit digit per cycle (least significant output digit first,
// into a small digit memory), and reads the digits back out most
// significant first. Each character is shown on rsp_out_char for exactly
// one cycle with rsp_valid high; the final one carries rsp_last. A '-' leads
// negative values. A bad alphabet gives a single word with rsp_base_invalid
// and rsp_last set and a zero character.
// A bad alphabet stops the check at the first bad character, or at the
// first check when the length itself is out of range.
// One value is in flight at a time; busy stays high until its last word is
// on the result ports. The receiver cannot stall, so no word is held back.
// Configuration words on the csr_ channel are always accepted and must only
// be sent while busy is low. Reset (synchronous) returns to idle, radix 10,
// alphabet "0123456789".
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "radix_ascii_formatter_defines.svh"

module radix_ascii_formatter
   import raf_pkg::*;
#(
   parameter int MAX_BASE   = 16,
   parameter int MAX_DIGITS = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic signed [VALUE_W-1:0] req_value,
   output logic                         rsp_valid,
   output logic [CHAR_W-1:0]            rsp_out_char,
   output logic                         rsp_last,
   output logic                         rsp_base_invalid,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_data
);

   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
   localparam int ADDR_W = $clog2(MAX_DIGITS);

   // One long-division step on a 4-bit digit: {quotient, remainder}.
   function automatic logic [2*DIGIT_W-1:0] nib_div(
      input logic [DIGIT_W-1:0] rem,
      input logic [DIGIT_W-1:0] nib,
      input logic [LEN_W-1:0]   radix
   );
      logic [DIGIT_W-1:0] r;
      logic [DIGIT_W-1:0] q;
      logic [LEN_W-1:0]   t;
      r = rem;
      q = '0;
      for (int i = DIGIT_W - 1; i >= 0; i--) begin
         t = {r, nib[i]};
         if (t >= radix) begin
            t    = t - radix;
            q[i] = 1'b1;
         end
         r = t[DIGIT_W-1:0];
      end
      return {q, r};
   endfunction

   raf_state_type state_ff, state_in;

   logic [LEN_W-1:0]      base_length_ff;
   logic [CSR_DATA_W-1:0] alpha_lo_ff;
   logic [CSR_DATA_W-1:0] alpha_hi_ff;

   logic [VALUE_W-1:0]     mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic                   nz_ff, nz_in;
   logic [NIB_CNT_W-1:0]   nib_ff, nib_in;
   logic [ALPHA_IDX_W-1:0] scan_ff, scan_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [ADDR_W-1:0]      ptr_ff, ptr_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]      rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_inv_ff, rsp_inv_in;

   logic [DIGIT_W-1:0]     digit_store [MAX_DIGITS];
   logic [DIGIT_W-1:0]     rd_data_ff;
   logic                   wr_en;

   logic [ALPHA_CHARS*CHAR_W-1:0] alphabet;
   logic [CHAR_W-1:0]             scan_char;
   logic                          len_bad;
   logic                          char_bad;
   logic                          dup_found;
   logic                          scan_last;
   logic [VALUE_W-1:0]            raw_value;
   logic [2*DIGIT_W-1:0]          div_out;
   logic [DIGIT_W-1:0]            quot_nib;
   logic [DIGIT_W-1:0]            rem_next;
   logic                          quot_nz;
   logic                          digit_done;
   logic                          div_finish;

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_char     = rsp_char_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_base_invalid = rsp_inv_ff;

   // ---------------------------------------------------------------- checks
   assign alphabet  = {alpha_hi_ff, alpha_lo_ff};
   assign scan_char = alphabet[{scan_ff, 3'b000} +: CHAR_W];
   assign len_bad   = (base_length_ff < LEN_W'(2)) || (base_length_ff > LEN_W'(MAX_BASE));
   assign scan_last = ({1'b0, scan_ff} == (base_length_ff - LEN_W'(1)));

   always_comb begin
      dup_found = 1'b0;
      for (int b = 0; b < ALPHA_CHARS; b++) begin
         if ((LEN_W'(b) > {1'b0, scan_ff}) && (LEN_W'(b) < base_length_ff) &&
             (alphabet[b*CHAR_W +: CHAR_W] == scan_char)) begin
            dup_found = 1'b1;
         end
      end
   end

   assign char_bad = dup_found || (scan_char == CHAR_PLUS) || (scan_char == CHAR_MINUS) ||
                     (scan_char < CHAR_LOW) || (scan_char > CHAR_HIGH);

   // -------------------------------------------------------------- divider
   assign raw_value  = req_value;
   assign div_out    = nib_div(rem_ff, mag_ff[VALUE_W-1 -: DIGIT_W], base_length_ff);
   assign quot_nib   = div_out[2*DIGIT_W-1:DIGIT_W];
   assign rem_next   = div_out[DIGIT_W-1:0];
   assign quot_nz    = nz_ff || (quot_nib != '0);
   assign digit_done = (nib_ff == NIB_CNT_W'(NIBBLES - 1));
   // The quotient is complete after the last nibble; stop once it is zero or the digit memory is full.
   assign div_finish = digit_done &&
                       (!quot_nz || ((cnt_ff + CNT_W'(1)) == CNT_W'(MAX_DIGITS)));
   assign wr_en      = (state_ff == S_DIVIDE) && digit_done;

   // ----------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            priority if (len_bad || char_bad) begin
               state_in = S_ERROR;
            end else if (scan_last) begin
               state_in = S_DIVIDE;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_DIVIDE: begin
            if (div_finish) begin
               state_in = neg_ff ? S_SIGN : S_FETCH;
            end
         end
         S_SIGN:  state_in = S_EMIT;
         S_FETCH: state_in = S_EMIT;
         S_EMIT: begin
            if (ptr_ff == '0) begin
               state_in = S_IDLE;
            end
         end
         S_ERROR: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // -------------------------------------------------- datapath and outputs
   always_comb begin
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      nz_in        = nz_ff;
      nib_in       = nib_ff;
      scan_in      = scan_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      rsp_valid_in = 1'b0;
      rsp_char_in  = CHAR_NONE;
      rsp_last_in  = 1'b0;
      rsp_inv_in   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mag_in  = raw_value[VALUE_W-1] ? (VALUE_W'(0) - raw_value) : raw_value;
               neg_in  = raw_value[VALUE_W-1];
               scan_in = '0;
            end
         end
         S_CHECK: begin
            scan_in = scan_ff + ALPHA_IDX_W'(1);
            rem_in  = '0;
            nz_in   = 1'b0;
            nib_in  = '0;
            cnt_in  = '0;
         end
         S_DIVIDE: begin
            mag_in = {mag_ff[VALUE_W-DIGIT_W-1:0], quot_nib};
            nib_in = nib_ff + NIB_CNT_W'(1);
            if (digit_done) begin
               rem_in = '0;
               nz_in  = 1'b0;
               cnt_in = cnt_ff + CNT_W'(1);
            end else begin
               rem_in = rem_next;
               nz_in  = quot_nz;
            end
         end
         S_SIGN: begin
            ptr_in       = cnt_ff[ADDR_W-1:0] - ADDR_W'(1);
            rsp_valid_in = 1'b1;
            rsp_char_in  = CHAR_MINUS;
         end
         S_FETCH: begin
            ptr_in = cnt_ff[ADDR_W-1:0] - ADDR_W'(1);
         end
         S_EMIT: begin
            ptr_in       = ptr_ff - ADDR_W'(1);
            rsp_valid_in = 1'b1;
            rsp_char_in  = alphabet[{rd_data_ff, 3'b000} +: CHAR_W];
            rsp_last_in  = (ptr_ff == '0);
         end
         S_ERROR: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            rsp_inv_in   = 1'b1;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      nz_ff       <= nz_in;
      nib_ff      <= nib_in;
      scan_ff     <= scan_in;
      ptr_ff      <= ptr_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_inv_ff  <= rsp_inv_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_length_ff <= BASE_LENGTH_RST;
         alpha_lo_ff    <= ALPHA_LOW_RST;
         alpha_hi_ff    <= ALPHA_HIGH_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (raf_csr_type'(csr_index))
            CSR_BASE_LENGTH: base_length_ff <= csr_data[LEN_W-1:0];
            CSR_ALPHA_LOW:   alpha_lo_ff    <= csr_data;
            CSR_ALPHA_HIGH:  alpha_hi_ff    <= csr_data;
            default: begin
               base_length_ff <= base_length_ff;
            end
         endcase
      end
   end

   // Digits go in least significant first and come out from the top down.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_store[cnt_ff[ADDR_W-1:0]] <= rem_next;
      end
      rd_data_ff <= digit_store[ptr_in];
   end

   // ----------------------------------------------------------- assertions
   `RAF_ASSERT_NEXT(a_busy_after_start, clock, reset, start && !busy, busy,
                    "busy did not rise after a word was taken")
   `RAF_ASSERT_NOW(a_error_word, clock, reset, rsp_valid && rsp_base_invalid,
                   rsp_last && (rsp_out_char == CHAR_NONE), "malformed error word")
   `RAF_ASSERT_NOW(a_radix_range, clock, reset, state_ff == S_DIVIDE,
                   (base_length_ff >= LEN_W'(2)) && (base_length_ff <= LEN_W'(MAX_BASE)),
                   "division running with an unchecked radix")
   `RAF_ASSERT_NOW(a_rsp_in_item, clock, reset, rsp_valid, $past(busy),
                   "result word outside an item")
   `RAF_ASSERT_NOW(a_digit_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(MAX_DIGITS),
                   "digit count beyond the digit memory")

endmodule

`default_nettype wire
